// ===== src/pwifd_pkg.sv =====
// Shared types and constants for the pulse-width IR frame decoder.
// No dependencies; every other file in src imports this package.
package pwifd_pkg;

  localparam int TICK_W    = 15;                  // tick count field width
  localparam int US_W      = 15;                  // microsecond register width
  localparam int TPT_W     = 10;                  // ticks_per_10us width
  localparam int FACT_W    = US_W + 1;            // target +/- margin factor
  localparam int THR_W     = FACT_W + TPT_W + 1;  // factor * 2 * tpt
  localparam int WIN_N     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 6;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = Q_PTR_W + 1;

  localparam logic [CNT_W-1:0] SHORT_BITS = CNT_W'(16);
  localparam logic [CNT_W-1:0] LONG_BITS  = CNT_W'(32);

  localparam logic [0:0]       RST_ACTIVE_LEVEL = 1'b0;
  localparam logic [TPT_W-1:0] RST_TPT          = TPT_W'(10);
  localparam logic [US_W-1:0]  RST_START_US     = US_W'(3000);
  localparam logic [US_W-1:0]  RST_ONE_US       = US_W'(1600);
  localparam logic [US_W-1:0]  RST_ZERO_US      = US_W'(800);
  localparam logic [US_W-1:0]  RST_GAP_US       = US_W'(600);
  localparam logic [US_W-1:0]  RST_MARGIN_US    = US_W'(200);

  typedef enum logic [1:0] {
    WIN_START,
    WIN_ONE,
    WIN_ZERO,
    WIN_GAP
  } win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL,
    REG_TICKS_PER_10US,
    REG_START_PULSE,
    REG_ONE_PULSE,
    REG_ZERO_PULSE,
    REG_GAP,
    REG_MARGIN
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_HDR,
    ST_BAD_MARK,
    ST_BAD_BIT,
    ST_EARLY_END
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_MARK,
    PH_DATA,
    PH_DROP
  } phase_t;

  typedef logic [THR_W-1:0] thr_val_t;

  // Window bounds in units of (20*ticks + tpt): lo is inclusive, hi exclusive
  typedef struct packed {
    thr_val_t [WIN_N-1:0] lo;
    thr_val_t [WIN_N-1:0] hi;
  } thr_set_t;

  // Classified pulse pair handed from the front to the back
  typedef struct packed {
    logic hdr_ok;
    logic one_ok;
    logic zero_ok;
    logic last;
  } cls_t;

endpackage

// ===== src/pwifd_cfg.sv =====
// Configuration registers and window threshold sequencer.
// Depends on pwifd_pkg; one shared multiplier fills eight bounds after each write.
module pwifd_cfg import pwifd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [US_W-1:0]      wr_data,
  output logic                 active_level,
  output logic [TPT_W-1:0]     tpt_eff,
  output thr_set_t             thr,
  output logic                 thr_ready
);

  logic              act_r;
  logic [TPT_W-1:0]  tpt_r;
  logic [US_W-1:0]   start_r, one_r, zero_r, gap_r, margin_r;
  logic              run_r, run_nxt;
  logic [2:0]        idx_r, idx_nxt;
  thr_val_t          lo_r [WIN_N];
  thr_val_t          hi_r [WIN_N];

  logic [US_W-1:0]   target;
  logic [FACT_W-1:0] fact_lo, fact_hi, fact;
  logic [TPT_W:0]    tpt2;
  thr_val_t          prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= RST_ACTIVE_LEVEL;
      tpt_r    <= RST_TPT;
      start_r  <= RST_START_US;
      one_r    <= RST_ONE_US;
      zero_r   <= RST_ZERO_US;
      gap_r    <= RST_GAP_US;
      margin_r <= RST_MARGIN_US;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_ACTIVE_LEVEL:   act_r    <= wr_data[0];
        REG_TICKS_PER_10US: tpt_r    <= wr_data[TPT_W-1:0];
        REG_START_PULSE:    start_r  <= wr_data;
        REG_ONE_PULSE:      one_r    <= wr_data;
        REG_ZERO_PULSE:     zero_r   <= wr_data;
        REG_GAP:            gap_r    <= wr_data;
        REG_MARGIN:         margin_r <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (win_t'(idx_r[1:0]))
      WIN_START: target = start_r;
      WIN_ONE:   target = one_r;
      WIN_ZERO:  target = zero_r;
      WIN_GAP:   target = gap_r;
      default:   target = gap_r;
    endcase
  end

  assign tpt_eff = (tpt_r == '0) ? TPT_W'(1) : tpt_r;
  assign tpt2    = {tpt_eff, 1'b0};

  // us > target - margin  <=>  20t + tpt >= (target - margin + 1) * 2tpt; clamp at zero
  assign fact_lo = (margin_r > target) ? '0
                 : FACT_W'({1'b0, target} - {1'b0, margin_r} + FACT_W'(1));
  assign fact_hi = {1'b0, target} + {1'b0, margin_r};
  assign fact    = idx_r[2] ? fact_hi : fact_lo;
  assign prod    = THR_W'(fact) * tpt2;

  // Restart the sweep on reset and on every write
  always_comb begin
    run_nxt = run_r;
    idx_nxt = idx_r;
    if (wr_en) begin
      run_nxt = 1'b1;
      idx_nxt = '0;
    end else if (run_r) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == 3'd7) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b1;
      idx_r <= '0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_r && !wr_en) begin
      if (idx_r[2]) hi_r[idx_r[1:0]] <= prod;
      else          lo_r[idx_r[1:0]] <= prod;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      thr.lo[i] = lo_r[i];
      thr.hi[i] = hi_r[i];
    end
  end

  assign active_level = act_r;
  assign thr_ready    = !run_r;

endmodule

// ===== src/pwifd_front.sv =====
// Front end: accepts pulse pairs, scales durations and classifies each pair.
// Depends on pwifd_pkg; thresholds come from pwifd_cfg.
module pwifd_front import pwifd_pkg::*; #(
  parameter int DURATION_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              high_level,
  input  logic [TICK_W-1:0] high_ticks,
  input  logic              low_level,
  input  logic [TICK_W-1:0] low_ticks,
  input  logic              last_in_buffer,
  input  logic              active_level,
  input  logic [TPT_W-1:0]  tpt_eff,
  input  thr_set_t          thr,
  input  logic              thr_ready,
  input  logic              q_full,
  output logic              q_push,
  output cls_t              q_data,
  output logic              busy
);

  localparam int TB = (DURATION_BITS < TICK_W) ? DURATION_BITS : TICK_W;
  localparam int AW = TB + 5;

  function automatic logic in_win(input logic [AW-1:0] a, input thr_val_t lo,
                                  input thr_val_t hi);
    thr_val_t ax;
    ax = THR_W'(a);
    return (ax >= lo) && (ax < hi);
  endfunction

  logic              s1_v_r, s1_v_nxt;
  logic              s1_hl_r, s1_ll_r, s1_last_r;
  logic [TICK_W-1:0] s1_ht_r, s1_lt_r;
  logic              s2_v_r, s2_v_nxt;
  logic [AW-1:0]     s2_ah_r, s2_al_r;
  logic              s2_lv_r, s2_gap0_r, s2_last_r;

  logic              s1_take, s1_adv, s2_take, s2_adv;
  logic [TB-1:0]     th, tl;
  logic [AW-1:0]     ah, al;
  logic              pulse_start, pulse_one, pulse_zero, gap_win, bit_gap;

  assign s2_adv   = s2_v_r && !q_full;
  assign s2_take  = !s2_v_r || s2_adv;
  assign s1_adv   = s1_v_r && s2_take;
  assign s1_take  = !s1_v_r || s1_adv;
  assign in_ready = thr_ready && s1_take;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_take) s1_v_nxt = in_valid && in_ready;
    s2_v_nxt = s2_v_r;
    if (s2_take) s2_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_hl_r   <= high_level;
      s1_ht_r   <= high_ticks;
      s1_ll_r   <= low_level;
      s1_lt_r   <= low_ticks;
      s1_last_r <= last_in_buffer;
    end
  end

  // 20*t + tpt, the numerator of the rounded microsecond conversion
  assign th = s1_ht_r[TB-1:0];
  assign tl = s1_lt_r[TB-1:0];
  assign ah = (AW'(th) << 4) + (AW'(th) << 2) + AW'(tpt_eff);
  assign al = (AW'(tl) << 4) + (AW'(tl) << 2) + AW'(tpt_eff);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ah_r   <= ah;
      s2_al_r   <= al;
      s2_lv_r   <= (s1_hl_r == active_level) && (s1_ll_r != active_level);
      s2_gap0_r <= (tl == '0);
      s2_last_r <= s1_last_r;
    end
  end

  assign pulse_start = in_win(s2_ah_r, thr.lo[WIN_START], thr.hi[WIN_START]);
  assign pulse_one   = in_win(s2_ah_r, thr.lo[WIN_ONE],   thr.hi[WIN_ONE]);
  assign pulse_zero  = in_win(s2_ah_r, thr.lo[WIN_ZERO],  thr.hi[WIN_ZERO]);
  assign gap_win     = in_win(s2_al_r, thr.lo[WIN_GAP],   thr.hi[WIN_GAP]);
  assign bit_gap     = s2_gap0_r || gap_win;

  assign q_push         = s2_adv;
  assign q_data.hdr_ok  = s2_lv_r && pulse_start && gap_win;
  assign q_data.one_ok  = s2_lv_r && pulse_one && bit_gap;
  assign q_data.zero_ok = s2_lv_r && pulse_zero && bit_gap;
  assign q_data.last    = s2_last_r;

  assign busy = s1_v_r || s2_v_r;

endmodule

// ===== src/pwifd_fifo.sv =====
// Short queue of classified pairs between the front and the back.
// Depends on pwifd_pkg for the entry type and depth.
module pwifd_fifo import pwifd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  input  logic pop,
  output cls_t pop_data,
  output logic full,
  output logic not_empty
);

  cls_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);

endmodule

// ===== src/pwifd_back.sv =====
// Back end: frame state machine, bit shifter and the result register.
// Depends on pwifd_pkg; pops classified pairs from pwifd_fifo.
module pwifd_back import pwifd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cls_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           status,
  output logic [DATA_W-1:0] data,
  output logic [CNT_W-1:0]  bit_count
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   bits_r, bits_nxt;
  logic               wide_r, wide_nxt;
  logic [DATA_W-1:0]  shift_r, shift_nxt;
  logic               out_v_r;
  status_t            st_r;
  logic [DATA_W-1:0]  word_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               take;
  logic               emit;
  status_t            emit_st;
  logic [DATA_W-1:0]  emit_word;
  logic [CNT_W-1:0]   emit_cnt;
  logic               bit_val;
  logic               bit_ok;
  logic [CNT_W-1:0]   bits_dec;
  logic               frame_done;

  assign take       = q_valid && (!out_v_r || out_ready);
  assign q_pop      = take;
  assign bit_ok     = q_data.one_ok || q_data.zero_ok;
  assign bit_val    = q_data.one_ok;
  assign bits_dec   = bits_r - CNT_W'(1);
  assign frame_done = (bits_dec == '0) || (bits_dec > LONG_BITS);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT: begin
        if (!q_data.hdr_ok)  phase_nxt = q_data.last ? PH_HUNT : PH_DROP;
        else if (!q_data.last) phase_nxt = PH_MARK;
      end
      PH_MARK: begin
        if (!bit_ok)         phase_nxt = q_data.last ? PH_HUNT : PH_DROP;
        else if (q_data.last) phase_nxt = PH_HUNT;
        else                 phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (!bit_ok)         phase_nxt = q_data.last ? PH_HUNT : PH_DROP;
        else if (frame_done || q_data.last) phase_nxt = PH_HUNT;
      end
      PH_DROP: begin
        if (q_data.last) phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // Results and datapath
  always_comb begin
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_word = '0;
    emit_cnt  = '0;
    bits_nxt  = bits_r;
    wide_nxt  = wide_r;
    shift_nxt = shift_r;
    case (phase_r)
      PH_HUNT: begin
        shift_nxt = '0;
        bits_nxt  = '0;
        if (!q_data.hdr_ok) begin
          emit    = 1'b1;
          emit_st = ST_BAD_HDR;
        end else if (q_data.last) begin
          emit    = 1'b1;
          emit_st = ST_EARLY_END;
        end
      end
      PH_MARK: begin
        shift_nxt = '0;
        if (!bit_ok) begin
          emit     = 1'b1;
          emit_st  = ST_BAD_MARK;
          bits_nxt = '0;
        end else begin
          // zero is tested first for the size marker
          wide_nxt = !q_data.zero_ok;
          if (q_data.last) begin
            emit     = 1'b1;
            emit_st  = ST_EARLY_END;
            bits_nxt = '0;
          end else begin
            bits_nxt = q_data.zero_ok ? SHORT_BITS : LONG_BITS;
          end
        end
      end
      PH_DATA: begin
        if (!bit_ok) begin
          emit      = 1'b1;
          emit_st   = ST_BAD_BIT;
          bits_nxt  = '0;
          shift_nxt = '0;
        end else if (frame_done) begin
          emit      = 1'b1;
          emit_st   = ST_OK;
          emit_word = {shift_r[DATA_W-2:0], bit_val};
          emit_cnt  = wide_r ? LONG_BITS : SHORT_BITS;
          bits_nxt  = '0;
          shift_nxt = '0;
        end else if (q_data.last) begin
          emit      = 1'b1;
          emit_st   = ST_EARLY_END;
          bits_nxt  = '0;
          shift_nxt = '0;
        end else begin
          bits_nxt  = bits_dec;
          shift_nxt = {shift_r[DATA_W-2:0], bit_val};
        end
      end
      PH_DROP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      bits_r  <= '0;
      wide_r  <= 1'b0;
      shift_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        bits_r  <= bits_nxt;
        wide_r  <= wide_nxt;
        shift_r <= shift_nxt;
        out_v_r <= emit;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      st_r   <= emit_st;
      word_r <= emit_word;
      cnt_r  <= emit_cnt;
    end
  end

  assign out_valid = out_v_r;
  assign status    = st_r;
  assign data      = word_r;
  assign bit_count = cnt_r;

endmodule

// ===== src/pulse_width_ir_frame_decoder_top.sv =====
// Pulse-width IR frame decoder, top level.
// Depends on pwifd_pkg, pwifd_cfg, pwifd_front, pwifd_fifo and pwifd_back.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata (pulse pair), in_tlast
//   out_     master     out_tvalid/tready    out_tdata (word, width), out_tuser
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pulse pair per cycle sustained while out_tready stays high; a pair's result reaches
// out_tvalid through the input register, scaling register, queue and result register.
// After reset and after each configuration write, a shared multiplier fills the
// eight window bounds one after another; in_tready stays low meanwhile.
// A stalled result first blocks the back end; the queue and front keep filling until the queue is full.
module pulse_width_ir_frame_decoder_top import pwifd_pkg::*; #(
  parameter int DURATION_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [0] high_level, [15:1] high_ticks, [16] low_level, [31:17] low_ticks
  input  logic [31:0]          in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [31:0] data, [37:32] bit_count, [39:38] zero
  output logic [39:0]          out_tdata,
  // [2:0] status
  output logic [2:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [US_W-1:0]      cfg_data
);

  logic              cfg_wr;
  logic              active_level;
  logic [TPT_W-1:0]  tpt_eff;
  thr_set_t          thr;
  logic              thr_ready;
  logic              front_busy;
  logic              q_push, q_pop, q_full, q_not_empty;
  cls_t              q_in, q_out;
  status_t           status;
  logic [DATA_W-1:0] data;
  logic [CNT_W-1:0]  bit_count;

  assign cfg_ready = !front_busy && !q_not_empty;
  assign cfg_wr    = cfg_valid && cfg_ready;

  pwifd_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_wr),
    .wr_index     (cfg_index),
    .wr_data      (cfg_data),
    .active_level (active_level),
    .tpt_eff      (tpt_eff),
    .thr          (thr),
    .thr_ready    (thr_ready)
  );

  pwifd_front #(
    .DURATION_BITS (DURATION_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .high_level     (in_tdata[0]),
    .high_ticks     (in_tdata[15:1]),
    .low_level      (in_tdata[16]),
    .low_ticks      (in_tdata[31:17]),
    .last_in_buffer (in_tlast),
    .active_level   (active_level),
    .tpt_eff        (tpt_eff),
    .thr            (thr),
    .thr_ready      (thr_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in),
    .busy           (front_busy)
  );

  pwifd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  pwifd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .data      (data),
    .bit_count (bit_count)
  );

  assign out_tdata = {2'b00, bit_count, data};
  assign out_tuser = status;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pulse_width_ir_frame_decoder_top: drives pulse pairs and register
// writes, predicts each frame result in a scoreboard class. Depends on pwifd_pkg and the RTL.
module tb import pwifd_pkg::*;;

  typedef struct packed {
    logic              high_level;
    logic [TICK_W-1:0] high_ticks;
    logic              low_level;
    logic [TICK_W-1:0] low_ticks;
    logic              last;
  } pulse_pair_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  width;
  } frame_result_t;

  typedef struct {
    logic             level;
    logic [TPT_W-1:0] rate;
    logic [US_W-1:0]  start;
    logic [US_W-1:0]  one;
    logic [US_W-1:0]  zero;
    logic [US_W-1:0]  gap;
    logic [US_W-1:0]  margin;
  } decoder_cfg_t;

  class ir_frame_scoreboard;
    logic              active_level;
    logic [TPT_W-1:0]  rate;
    logic [US_W-1:0]   start_us, one_us, zero_us, gap_us, tol_us;
    phase_t            phase;
    logic [CNT_W-1:0]  bits_left;
    logic              wide;
    logic [DATA_W-1:0] shift_word;
    frame_result_t     expected_q[$];
    int                err_count;

    function new();
      active_level = RST_ACTIVE_LEVEL;
      rate         = RST_TPT;
      start_us     = RST_START_US;
      one_us       = RST_ONE_US;
      zero_us      = RST_ZERO_US;
      gap_us       = RST_GAP_US;
      tol_us       = RST_MARGIN_US;
      phase        = PH_HUNT;
      bits_left    = '0;
      wide         = 1'b0;
      shift_word   = '0;
      err_count    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [US_W-1:0] val);
      case (idx)
        REG_ACTIVE_LEVEL:   active_level = val[0];
        REG_TICKS_PER_10US: rate = val[TPT_W-1:0];
        REG_START_PULSE:    start_us = val;
        REG_ONE_PULSE:      one_us = val;
        REG_ZERO_PULSE:     zero_us = val;
        REG_GAP:            gap_us = val;
        REG_MARGIN:         tol_us = val;
        default: ;
      endcase
    endfunction

    // Rounded microseconds against the open window (target - margin, target + margin)
    function bit in_window(logic [TICK_W-1:0] ticks, logic [US_W-1:0] target);
      longint r;
      longint dur;
      r = (rate == 0) ? 1 : longint'(rate);
      dur = (20 * longint'(ticks) + r) / (2 * r);
      return dur > longint'(target) - longint'(tol_us) &&
             dur < longint'(target) + longint'(tol_us);
    endfunction

    function bit levels_ok(pulse_pair_t p);
      return p.high_level == active_level && p.low_level != active_level;
    endfunction

    function bit fits_header(pulse_pair_t p);
      return levels_ok(p) && in_window(p.high_ticks, start_us) && in_window(p.low_ticks, gap_us);
    endfunction

    function bit fits_bit(pulse_pair_t p, logic [US_W-1:0] pulse);
      return levels_ok(p) && in_window(p.high_ticks, pulse) &&
             (p.low_ticks == 0 || in_window(p.low_ticks, gap_us));
    endfunction

    function void post_error(status_t st, logic last_pair);
      phase      = last_pair ? PH_HUNT : PH_DROP;
      bits_left  = '0;
      shift_word = '0;
      expected_q.push_back('{status: st, word: '0, width: '0});
    endfunction

    // Advance the frame state by one pair; returns 1 when the pair is dropped unseen
    function bit note_pair(pulse_pair_t p);
      logic bit_val;
      case (phase)
        PH_HUNT: begin
          if (!fits_header(p)) post_error(ST_BAD_HDR, p.last);
          else if (p.last) post_error(ST_EARLY_END, 1'b1);
          else begin
            phase      = PH_MARK;
            shift_word = '0;
          end
        end
        PH_MARK: begin
          // zero wins over one for the size marker
          if (fits_bit(p, zero_us)) wide = 1'b0;
          else if (fits_bit(p, one_us)) wide = 1'b1;
          else begin
            post_error(ST_BAD_MARK, p.last);
            return 1'b0;
          end
          if (p.last) post_error(ST_EARLY_END, 1'b1);
          else begin
            bits_left  = wide ? LONG_BITS : SHORT_BITS;
            shift_word = '0;
            phase      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (fits_bit(p, one_us)) bit_val = 1'b1;
          else if (fits_bit(p, zero_us)) bit_val = 1'b0;
          else begin
            post_error(ST_BAD_BIT, p.last);
            return 1'b0;
          end
          shift_word = {shift_word[DATA_W-2:0], bit_val};
          bits_left  = bits_left - 1'b1;
          if (bits_left == 0 || bits_left > LONG_BITS) begin
            expected_q.push_back('{status: ST_OK, word: shift_word,
                                   width: wide ? LONG_BITS : SHORT_BITS});
            phase      = PH_HUNT;
            bits_left  = '0;
            shift_word = '0;
          end else if (p.last) begin
            post_error(ST_EARLY_END, 1'b1);
          end
        end
        default: begin
          if (p.last) phase = PH_HUNT;
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void check_result(logic [2:0] st, logic [DATA_W-1:0] word, logic [CNT_W-1:0] width);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result status %0d data %h count %0d", $time, st, word, width);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || word !== e.word || width !== e.width) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: mismatch status exp %0d got %0d, data exp %h got %h, count exp %0d got %0d",
                   $time, e.status, st, e.word, word, e.width, width);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic [2:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [US_W-1:0]      cfg_data;

  ir_frame_scoreboard sb = new();
  pulse_pair_t        pulse_q[$];
  int                 sent_items;
  int                 in_idle_pct;
  int                 out_stall_pct;
  logic               hold_go = 1'b0;
  logic               hold_off = 1'b0;

  pulse_width_ir_frame_decoder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) out_tready <= !hold_off && ($urandom_range(99) >= out_stall_pct);

  // Long receiver hold-off so the queue fills and in_tready drops
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[31:0], out_tdata[37:32]);
  end

  function automatic pulse_pair_t pair_of(logic hl, int ht, logic ll, int lt, logic last);
    pulse_pair_t p;
    p.high_level = hl;
    p.high_ticks = TICK_W'(ht);
    p.low_level  = ll;
    p.low_ticks  = TICK_W'(lt);
    p.last       = last;
    return p;
  endfunction

  // Ticks for a duration inside the window, now and then exactly on its edge
  function automatic logic [TICK_W-1:0] dur_ticks(logic [US_W-1:0] nominal);
    longint m;
    longint r;
    longint us;
    longint t;
    m = sb.tol_us;
    r = (sb.rate == 0) ? 1 : longint'(sb.rate);
    if ($urandom_range(49) == 0)
      us = $urandom_range(1) ? longint'(nominal) + m : longint'(nominal) - m;
    else
      us = longint'(nominal) + longint'($urandom_range(0, 2 * m)) - m;
    if (us < 0) return '0;
    t = (us * r + 5) / 10;
    return (t > 32767) ? TICK_W'(32767) : TICK_W'(t);
  endfunction

  function automatic pulse_pair_t make_pair(logic [US_W-1:0] nominal);
    pulse_pair_t p;
    p.high_level = sb.active_level;
    p.low_level  = !sb.active_level;
    p.high_ticks = dur_ticks(nominal);
    p.low_ticks  = ($urandom_range(4) == 0) ? '0 : dur_ticks(sb.gap_us);
    p.last       = 1'b0;
    case ($urandom_range(99))
      0: p.high_level = !p.high_level;
      1: p.low_level = !p.low_level;
      2: p.high_ticks = TICK_W'($urandom);
      3: p.low_ticks = TICK_W'($urandom);
      default: ;
    endcase
    return p;
  endfunction

  function automatic decoder_cfg_t random_setting();
    decoder_cfg_t c;
    int unsigned  lim;
    int unsigned  unit;
    c.level = 1'($urandom_range(1));
    c.rate  = ($urandom_range(3) == 0) ? TPT_W'($urandom_range(1, 20))
                                       : TPT_W'($urandom_range(1, 1000));
    lim = 327670 / c.rate;
    if (lim > 32767) lim = 32767;
    unit = lim / 16;
    c.margin = US_W'($urandom_range((c.rate < 10) ? 12 : 2, unit / 2));
    c.gap    = US_W'($urandom_range(unit, 3 * unit));
    c.zero   = US_W'($urandom_range(4 * unit, 5 * unit));
    c.one    = US_W'($urandom_range(7 * unit, 8 * unit));
    c.start  = US_W'($urandom_range(11 * unit, 15 * unit));
    return c;
  endfunction

  // One capture buffer: mostly well-formed frames, some noise, some cut short
  task automatic queue_capture();
    pulse_pair_t cap[$];
    bit          wide;
    int          keep;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) cap.push_back({$urandom, $urandom_range(3) == 0});
    end else begin
      repeat ($urandom_range(1, 2)) begin
        wide = 1'($urandom_range(1));
        cap.push_back(make_pair(sb.start_us));
        cap.push_back(make_pair(wide ? sb.one_us : sb.zero_us));
        repeat (wide ? 32 : 16) cap.push_back(make_pair($urandom_range(1) ? sb.one_us : sb.zero_us));
      end
      if ($urandom_range(6) == 0) begin
        keep = $urandom_range(1, cap.size());
        cap = cap[0:keep-1];
      end
    end
    if ($urandom_range(9) != 0) cap[cap.size()-1].last = 1'b1;
    foreach (cap[i]) pulse_q.push_back(cap[i]);
  endtask

  // Entered and left just after a falling edge
  task automatic send_pair(input pulse_pair_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.low_ticks, p.low_level, p.high_ticks, p.high_level};
    in_tlast  <= p.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(sb.note_pair(p));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [US_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(input decoder_cfg_t c, input bit noisy);
    logic [US_W-1:0] junk;
    junk = noisy ? US_W'($urandom) : '0;
    write_reg(REG_ACTIVE_LEVEL, {junk[US_W-1:1], c.level});
    write_reg(REG_TICKS_PER_10US, {junk[US_W-1:TPT_W], c.rate});
    write_reg(REG_START_PULSE, c.start);
    write_reg(REG_ONE_PULSE, c.one);
    write_reg(REG_ZERO_PULSE, c.zero);
    write_reg(REG_GAP, c.gap);
    write_reg(REG_MARGIN, c.margin);
    cfg_valid <= 1'b0;
  endtask

  // Wait out every expected result, then the pipeline depth for dropped pairs
  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    decoder_cfg_t fixed_cfg[4];
    pulse_pair_t  seq[$];
    logic [15:0]  pattern;
    int           ph;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ACTIVE_LEVEL;
    cfg_data      = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    sent_items    = 0;
    fixed_cfg[0] = '{level: 1, rate: 1, start: 3000, one: 1600, zero: 800, gap: 600, margin: 200};
    fixed_cfg[1] = '{level: 0, rate: 1000, start: 300, one: 160, zero: 80, gap: 60, margin: 20};
    // zero rate acts as one; widest margin and zero gap
    fixed_cfg[2] = '{level: 1, rate: 0, start: 32767, one: 20000, zero: 10000, gap: 0,
                     margin: 32767};
    // zero margin: no pair can match
    fixed_cfg[3] = '{level: 0, rate: 7, start: 9000, one: 2250, zero: 562, gap: 562, margin: 0};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset settings: ticks equal microseconds
    pattern = 16'hA5C3;
    seq.push_back(pair_of(0, 3000, 1, 600, 0));
    seq.push_back(pair_of(0, 800, 1, 0, 0));
    for (int i = 15; i >= 0; i--)
      seq.push_back(pair_of(0, pattern[i] ? 1600 : 800, 1, (i % 3 == 0) ? 0 : 600, i == 0));
    seq.push_back(pair_of(1, 32767, 0, 0, 0));       // bad header, then drop
    seq.push_back(pair_of(0, 0, 0, 0, 1));           // dropped, ends buffer
    seq.push_back(pair_of(0, 3000, 1, 600, 1));      // header at buffer end
    seq.push_back(pair_of(0, 3000, 1, 600, 0));
    seq.push_back(pair_of(0, 0, 1, 32767, 1));       // bad size marker
    seq.push_back(pair_of(0, 3000, 1, 600, 0));
    seq.push_back(pair_of(0, 1600, 1, 600, 0));      // wide frame
    seq.push_back(pair_of(1, 1600, 0, 600, 0));      // data bit with swapped levels
    seq.push_back(pair_of(0, 3000, 1, 600, 1));      // dropped
    seq.push_back(pair_of(0, 2800, 1, 600, 1));      // pulse on the window edge
    foreach (seq[i]) send_pair(seq[i]);
    in_tvalid <= 1'b0;
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 55; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 11; out_stall_pct = 11; end
      endcase
      if (ph >= 1 && ph <= 4) apply_setting(fixed_cfg[ph-1], 1'b0);
      else if (ph > 4) apply_setting(random_setting(), 1'b1);
      @(negedge clk);
      sent_items = 0;
      while (sent_items < 180 || pulse_q.size() != 0) begin
        if (pulse_q.size() == 0) queue_capture();
        if (ph == 0 && sent_items == 40) hold_go = 1'b1;
        send_pair(pulse_q.pop_front());
      end
      in_tvalid <= 1'b0;
      drain();
    end

    if (sb.err_count == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
